@@ rtl/core/slr_pkg.sv @@
// ----------------------------------------------------------------------------
// slr_pkg: shared definitions for the stereo linear resampler
// Block geometry, fixed-point widths, sequencer states, the control bundle
// for the interpolation unit and the step clamping function.
// ----------------------------------------------------------------------------
package slr_pkg;

    localparam int BLOCK_SAMPLES = 1024;
    localparam int FRAC_BITS     = 16;
    localparam int MAX_OUT       = 64;

    localparam int SAMPLE_W = 16;
    localparam int STEP_W   = 17;
    localparam int IDX_W    = (BLOCK_SAMPLES > 2) ? $clog2(BLOCK_SAMPLES) : 1;
    localparam int CNT_W    = IDX_W + 1;
    localparam int POS_W    = IDX_W + FRAC_BITS;
    localparam int T_W      = FRAC_BITS + 1;
    localparam int N_W      = $clog2(MAX_OUT + 1);
    localparam int DIFF_W   = SAMPLE_W + 1;
    localparam int PROD_W   = T_W + 1 + DIFF_W;
    localparam int SUM_W    = PROD_W + 1;

    // Q1.16 step limits
    localparam int STEP_ONE = 65536;
    localparam int STEP_MIN = 1024;
    localparam int STEP_WIDE_W = STEP_W + 8;
    localparam int STEP_SHL = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
    localparam int STEP_SHR = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_MUL_L,
        S_MUL_R,
        S_FIN_R,
        S_OUT
    } slr_state_t;

    typedef struct packed {
        logic mul_left;
        logic mul_right;
        logic fin_left;
        logic fin_right;
    } slr_mul_ctl_t;

    // Clamp the written step to [1/64, 1.0] and rescale to FRAC_BITS.
    function automatic logic [T_W-1:0] eff_step(input logic [STEP_W-1:0] step);
        logic [STEP_W-1:0]      s;
        logic [STEP_WIDE_W-1:0] wide;
        s = step;
        if (s == '0 || s > STEP_W'(STEP_ONE)) begin
            s = STEP_W'(STEP_ONE);
        end
        if (s < STEP_W'(STEP_MIN)) begin
            s = STEP_W'(STEP_MIN);
        end
        wide = STEP_WIDE_W'(s);
        wide = (wide << STEP_SHL) >> STEP_SHR;
        return wide[T_W-1:0];
    endfunction

endpackage

@@ rtl/core/slr_lerp_unit.sv @@
// ----------------------------------------------------------------------------
// slr_lerp_unit: shared interpolation multiplier
// One signed multiplier computes t*(b-a) for the left channel and then the
// right; a following add and truncate-toward-zero step forms each result.
// ----------------------------------------------------------------------------
module slr_lerp_unit
    import slr_pkg::*;
(
    input  logic                       clk,
    input  slr_mul_ctl_t               ctl,
    input  logic [T_W-1:0]             t,
    input  logic signed [SAMPLE_W-1:0] a_left,
    input  logic signed [SAMPLE_W-1:0] b_left,
    input  logic signed [SAMPLE_W-1:0] a_right,
    input  logic signed [SAMPLE_W-1:0] b_right,
    output logic signed [SAMPLE_W-1:0] out_left,
    output logic signed [SAMPLE_W-1:0] out_right
);

    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [PROD_W-1:0]   prod_next;
    logic signed [SAMPLE_W-1:0] out_left_reg;
    logic signed [SAMPLE_W-1:0] out_right_reg;
    logic signed [SAMPLE_W-1:0] mul_a;
    logic signed [SAMPLE_W-1:0] mul_b;
    logic signed [DIFF_W-1:0]   diff;
    logic signed [SAMPLE_W-1:0] fin_a;
    logic signed [SAMPLE_W-1:0] fin_q;

    // a*2^F + t*(b-a), divided by 2^F truncating toward zero
    function automatic logic signed [SAMPLE_W-1:0] finish(
        input logic signed [SAMPLE_W-1:0] a,
        input logic signed [PROD_W-1:0]   p
    );
        logic signed [SUM_W-1:0] sum;
        logic signed [SUM_W-1:0] q;
        sum = (SUM_W'(a) <<< FRAC_BITS) + SUM_W'(p);
        q   = sum >>> FRAC_BITS;
        if (sum[SUM_W-1] && (sum[FRAC_BITS-1:0] != '0)) begin
            q = q + SUM_W'(1);
        end
        return q[SAMPLE_W-1:0];
    endfunction

    always_comb
    begin
        mul_a = ctl.mul_right ? a_right : a_left;
        mul_b = ctl.mul_right ? b_right : b_left;
        diff  = DIFF_W'(mul_b) - DIFF_W'(mul_a);
        prod_next = $signed({1'b0, t}) * diff;
        fin_a = ctl.fin_right ? a_right : a_left;
        fin_q = finish(fin_a, prod_reg);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.mul_left || ctl.mul_right) begin
            prod_reg <= prod_next;
        end
        if (ctl.fin_left) begin
            out_left_reg <= fin_q;
        end
        if (ctl.fin_right) begin
            out_right_reg <= fin_q;
        end
    end

    assign out_left  = out_left_reg;
    assign out_right = out_right_reg;

endmodule

@@ rtl/core/slr_ctrl.sv @@
// ----------------------------------------------------------------------------
// slr_ctrl: resampler sequencer and block state
// Holds the step register, sample history, block counters and position, and
// steps the interpolation unit through each output of an input transaction.
// ----------------------------------------------------------------------------
module slr_ctrl
    import slr_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_valid,
    input  logic [STEP_W-1:0]          cfg_data,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic signed [SAMPLE_W-1:0] in_left,
    input  logic signed [SAMPLE_W-1:0] in_right,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic                       last,
    output logic                       block_end,
    output slr_mul_ctl_t               ctl,
    output logic [T_W-1:0]             t,
    output logic signed [SAMPLE_W-1:0] a_left,
    output logic signed [SAMPLE_W-1:0] b_left,
    output logic signed [SAMPLE_W-1:0] a_right,
    output logic signed [SAMPLE_W-1:0] b_right
);

    localparam logic [IDX_W-1:0] I0_MAX    = IDX_W'(BLOCK_SAMPLES - 2);
    localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(BLOCK_SAMPLES - 1);
    localparam logic [CNT_W-1:0] CNT_BLOCK = CNT_W'(BLOCK_SAMPLES);
    localparam logic [CNT_W-1:0] CNT_LAST  = CNT_W'(BLOCK_SAMPLES - 1);
    localparam logic [N_W-1:0]   N_MAX     = N_W'(MAX_OUT);
    localparam logic [POS_W-1:0] POS_ONE   = POS_W'(1) << FRAC_BITS;
    localparam logic [POS_W:0]   POS_CAP   = (POS_W + 1)'(BLOCK_SAMPLES - 1) << FRAC_BITS;

    slr_state_t state_reg, state_next;

    logic [STEP_W-1:0]          step_reg;
    logic [IDX_W-1:0]           index_reg, index_next;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic [POS_W-1:0]           pos_reg, pos_next;
    logic [N_W-1:0]             n_reg, n_next;
    logic                       be_reg, be_next;
    logic signed [SAMPLE_W-1:0] prev_left_reg, prev_right_reg;
    logic signed [SAMPLE_W-1:0] cur_left_reg, cur_right_reg;

    logic [IDX_W-1:0] i0_raw;
    logic [IDX_W-1:0] i0;
    logic [POS_W-1:0] t_full;
    logic [POS_W:0]   pos_sum;
    logic             can_emit;
    logic             in_take;
    logic             retire;

    // interpolation point of the next output
    always_comb
    begin
        i0_raw = pos_reg[POS_W-1:FRAC_BITS];
        i0     = (i0_raw > I0_MAX) ? I0_MAX : i0_raw;
        t_full = pos_reg - {i0, {FRAC_BITS{1'b0}}};
        t      = (t_full > POS_ONE) ? T_W'(POS_ONE) : t_full[T_W-1:0];
        can_emit = (count_reg < CNT_BLOCK) && (n_reg < N_MAX)
                   && (({1'b0, i0} + (IDX_W + 1)'(1)) <= {1'b0, index_reg});
        pos_sum = {1'b0, pos_reg} + (POS_W + 1)'(eff_step(step_reg));
    end

    always_comb
    begin
        state_next = state_reg;
        index_next = index_reg;
        count_next = count_reg;
        pos_next   = pos_reg;
        n_next     = n_reg;
        be_next    = be_reg;
        ctl        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        retire     = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid) begin
                    n_next     = '0;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (index_reg != '0 && can_emit) begin
                    state_next = S_MUL_L;
                end
                else begin
                    retire     = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_MUL_L:
            begin
                ctl.mul_left = 1'b1;
                state_next   = S_MUL_R;
            end
            S_MUL_R:
            begin
                ctl.mul_right = 1'b1;
                ctl.fin_left  = 1'b1;
                state_next    = S_FIN_R;
            end
            S_FIN_R:
            begin
                // advance to the following output while this one is finished
                ctl.fin_right = 1'b1;
                be_next    = (count_reg == CNT_LAST);
                count_next = count_reg + CNT_W'(1);
                n_next     = n_reg + N_W'(1);
                pos_next   = (pos_sum > POS_CAP) ? POS_CAP[POS_W-1:0] : pos_sum[POS_W-1:0];
                state_next = S_OUT;
            end
            S_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready) begin
                    if (can_emit) begin
                        state_next = S_MUL_L;
                    end
                    else begin
                        retire     = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // close out the input transaction: new index, or wrap the block
        if (retire) begin
            if (index_reg == IDX_LAST) begin
                index_next = '0;
                count_next = '0;
                pos_next   = '0;
            end
            else begin
                index_next = index_reg + IDX_W'(1);
            end
        end
    end

    assign in_take   = in_valid && in_ready;
    assign last      = !can_emit;
    assign block_end = be_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg      <= S_IDLE;
            step_reg       <= STEP_W'(STEP_ONE);
            index_reg      <= '0;
            count_reg      <= '0;
            pos_reg        <= '0;
            n_reg          <= '0;
            be_reg         <= 1'b0;
            prev_left_reg  <= '0;
            prev_right_reg <= '0;
        end
        else begin
            state_reg <= state_next;
            index_reg <= index_next;
            count_reg <= count_next;
            pos_reg   <= pos_next;
            n_reg     <= n_next;
            be_reg    <= be_next;
            if (cfg_valid) begin
                step_reg <= cfg_data;
            end
            if (retire) begin
                prev_left_reg  <= cur_left_reg;
                prev_right_reg <= cur_right_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take) begin
            cur_left_reg  <= in_left;
            cur_right_reg <= in_right;
        end
    end

    assign a_left  = prev_left_reg;
    assign a_right = prev_right_reg;
    assign b_left  = cur_left_reg;
    assign b_right = cur_right_reg;

endmodule

@@ rtl/core/stereo_linear_resampler_core.sv @@
// Each result passes S_MUL_L, S_MUL_R and S_FIN_R, since the one multiplier
// serves left and right in turn, and is offered in S_OUT; before an input's
// first result comes S_EVAL. One input gives n results (n up to 64); the next
// input is taken only in S_IDLE. A stalled result holds the sequencer.
// Reset: asynchronous, active low; step returns to 1.0, block state to zero.
// ----------------------------------------------------------------------------
// stereo_linear_resampler_core: block-based stereo linear resampler
// Interpolates signed 16-bit stereo samples at a configurable Q1.16 step and
// emits each output as soon as both neighboring inputs are present.
// ----------------------------------------------------------------------------
module stereo_linear_resampler_core
    import slr_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [STEP_W-1:0]          cfg_data,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic signed [SAMPLE_W-1:0] in_left,
    input  logic signed [SAMPLE_W-1:0] in_right,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [SAMPLE_W-1:0] out_left,
    output logic signed [SAMPLE_W-1:0] out_right,
    output logic                       last,
    output logic                       block_end
);

    slr_mul_ctl_t               ctl;
    logic [T_W-1:0]             t;
    logic signed [SAMPLE_W-1:0] a_left;
    logic signed [SAMPLE_W-1:0] b_left;
    logic signed [SAMPLE_W-1:0] a_right;
    logic signed [SAMPLE_W-1:0] b_right;

    assign cfg_ready = 1'b1;

    slr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_left   (in_left),
        .in_right  (in_right),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .last      (last),
        .block_end (block_end),
        .ctl       (ctl),
        .t         (t),
        .a_left    (a_left),
        .b_left    (b_left),
        .a_right   (a_right),
        .b_right   (b_right)
    );

    slr_lerp_unit u_lerp (
        .clk       (clk),
        .ctl       (ctl),
        .t         (t),
        .a_left    (a_left),
        .b_left    (b_left),
        .a_right   (a_right),
        .b_right   (b_right),
        .out_left  (out_left),
        .out_right (out_right)
    );

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: testbench for stereo_linear_resampler_core
// Drives stereo samples and step writes through valid/ready channels, keeps
// its own model of the block position and interpolation, and compares every
// output transaction field by field.
// A short table of directed rows comes first; random phases with mixed steps
// and idling patterns follow.
// ----------------------------------------------------------------------------
module tb
    import slr_pkg::*;
();

    typedef enum int {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } idle_mode_t;

    typedef enum int {
        CHK_MODEL,
        CHK_NONE,
        CHK_ONE
    } row_check_t;

    typedef struct {
        logic signed [SAMPLE_W-1:0] left;
        logic signed [SAMPLE_W-1:0] right;
        logic                       last;
        logic                       block_end;
    } resamp_out_t;

    typedef struct {
        logic                       wr_step;
        logic [STEP_W-1:0]          step;
        logic signed [SAMPLE_W-1:0] left;
        logic signed [SAMPLE_W-1:0] right;
        row_check_t                 check;
        logic signed [SAMPLE_W-1:0] exp_left;
        logic signed [SAMPLE_W-1:0] exp_right;
    } dir_row_t;

    localparam int     DIR_ROWS     = 21;
    localparam int     RANDOM_ITEMS = 300;
    localparam int     SETTLE_CYC   = 8;
    localparam longint POS_CAP      = longint'(BLOCK_SAMPLES - 1) << FRAC_BITS;
    localparam longint FRAC_ONE     = longint'(1) << FRAC_BITS;

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [STEP_W-1:0]          cfg_data;
    logic                       in_valid;
    logic                       in_ready;
    logic signed [SAMPLE_W-1:0] in_left;
    logic signed [SAMPLE_W-1:0] in_right;
    logic                       out_valid;
    logic                       out_ready;
    logic signed [SAMPLE_W-1:0] out_left;
    logic signed [SAMPLE_W-1:0] out_right;
    logic                       last;
    logic                       block_end;

    // model state of the resampler
    logic [STEP_W-1:0]          step_now     = STEP_W'(STEP_ONE);
    logic signed [SAMPLE_W-1:0] held_l       = '0;
    logic signed [SAMPLE_W-1:0] held_r       = '0;
    logic [IDX_W-1:0]           in_slot      = '0;
    logic [CNT_W-1:0]           outs_in_blk  = '0;
    logic [POS_W-1:0]           interp_pos   = '0;

    resamp_out_t due_samples[$];
    resamp_out_t new_samples[$];

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int mismatches    = 0;

    dir_row_t dir_rows [DIR_ROWS] = '{
        '{1'b0, 17'd0,      16'sh8000, 16'sh7FFF, CHK_NONE,  16'sh0000, 16'sh0000},
        '{1'b0, 17'd0,      16'sh7FFF, 16'sh8000, CHK_ONE,   16'sh8000, 16'sh7FFF},
        '{1'b0, 17'd0,      16'sh0000, 16'sh0000, CHK_ONE,   16'sh7FFF, 16'sh8000},
        '{1'b0, 17'd0,      16'shFFFF, 16'sh0001, CHK_ONE,   16'sh0000, 16'sh0000},
        '{1'b0, 17'd0,      16'sh5555, 16'shAAAA, CHK_ONE,   16'shFFFF, 16'sh0001},
        '{1'b1, 17'd32768,  16'sh8000, 16'sh7FFF, CHK_MODEL, 16'sh0000, 16'sh0000},
        '{1'b0, 17'd0,      16'sh7FFF, 16'sh8000, CHK_MODEL, 16'sh0000, 16'sh0000},
        '{1'b0, 17'd0,      16'sh8000, 16'sh7FFF, CHK_MODEL, 16'sh0000, 16'sh0000},
        '{1'b1, 17'd0,      16'sh0064, 16'shFF9C, CHK_MODEL, 16'sh0000, 16'sh0000},
        '{1'b0, 17'd0,      16'shFFF9, 16'sh0007, CHK_MODEL, 16'sh0000, 16'sh0000},
        '{1'b1, 17'd1,      16'sh7FFF, 16'sh8000, CHK_MODEL, 16'sh0000, 16'sh0000},
        '{1'b0, 17'd0,      16'sh8000, 16'sh7FFF, CHK_MODEL, 16'sh0000, 16'sh0000},
        '{1'b1, 17'd1023,   16'sh3039, 16'shCFC7, CHK_MODEL, 16'sh0000, 16'sh0000},
        '{1'b1, 17'd1024,   16'shFFFD, 16'sh0003, CHK_MODEL, 16'sh0000, 16'sh0000},
        '{1'b1, 17'd131071, 16'sh7FFF, 16'sh7FFF, CHK_MODEL, 16'sh0000, 16'sh0000},
        '{1'b0, 17'd0,      16'sh8000, 16'sh8000, CHK_MODEL, 16'sh0000, 16'sh0000},
        '{1'b1, 17'd65535,  16'sh0001, 16'shFFFF, CHK_MODEL, 16'sh0000, 16'sh0000},
        '{1'b0, 17'd0,      16'sh8000, 16'sh7FFF, CHK_MODEL, 16'sh0000, 16'sh0000},
        '{1'b1, 17'd65536,  16'sh0000, 16'sh0000, CHK_MODEL, 16'sh0000, 16'sh0000},
        '{1'b1, 17'd40000,  16'sh7FFF, 16'sh8000, CHK_MODEL, 16'sh0000, 16'sh0000},
        '{1'b0, 17'd0,      16'sh8000, 16'sh7FFF, CHK_MODEL, 16'sh0000, 16'sh0000}
    };

    stereo_linear_resampler_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_left   (in_left),
        .in_right  (in_right),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_left  (out_left),
        .out_right (out_right),
        .last      (last),
        .block_end (block_end)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("Verification failed");
        $finish;
    end

    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Clamp the step to [1/64, 1.0] and scale it to the position's fraction.
    function automatic logic [T_W-1:0] frac_step(input logic [STEP_W-1:0] s);
        logic [STEP_W-1:0] q;
        if (s == '0 || s > STEP_W'(STEP_ONE))
            q = STEP_W'(STEP_ONE);
        else if (s < STEP_W'(STEP_MIN))
            q = STEP_W'(STEP_MIN);
        else
            q = s;
        return T_W'((longint'(q) << STEP_SHL) >> STEP_SHR);
    endfunction

    // (1-t)*a + t*b, truncated toward zero
    function automatic logic signed [SAMPLE_W-1:0] blend(
        input logic signed [SAMPLE_W-1:0] a,
        input logic signed [SAMPLE_W-1:0] b,
        input longint                     t
    );
        longint acc;
        acc = (FRAC_ONE - t) * longint'(a) + t * longint'(b);
        return SAMPLE_W'(acc / FRAC_ONE);
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] any_sample();
        case ($urandom_range(9))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return 16'sh0000;
            3: return 16'shFFFF;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    function automatic logic [STEP_W-1:0] any_step();
        case ($urandom_range(9))
            0: return '0;
            1: return STEP_W'($urandom_range(1, STEP_MIN - 1));
            2: return STEP_W'(STEP_MIN);
            3: return STEP_W'(STEP_ONE);
            4: return STEP_W'($urandom_range(STEP_ONE + 1, (1 << STEP_W) - 1));
            default: return STEP_W'($urandom_range(STEP_MIN, STEP_ONE));
        endcase
    endfunction

    // Work out the outputs that one accepted sample releases.
    task automatic interpolate_ahead(
        input logic signed [SAMPLE_W-1:0] l,
        input logic signed [SAMPLE_W-1:0] r
    );
        logic [T_W-1:0]   inc;
        logic [IDX_W-1:0] i0;
        logic [POS_W:0]   nxt;
        longint           t;
        int               n;
        resamp_out_t      o;
        new_samples.delete();
        inc = frac_step(step_now);
        n   = 0;
        if (in_slot != '0)
        begin
            while (outs_in_blk < BLOCK_SAMPLES && n < MAX_OUT)
            begin
                i0 = interp_pos[POS_W-1:FRAC_BITS];
                if (i0 > BLOCK_SAMPLES - 2)
                    i0 = IDX_W'(BLOCK_SAMPLES - 2);
                if (i0 + 1 > in_slot)
                    break;
                t = longint'(interp_pos) - (longint'(i0) << FRAC_BITS);
                if (t > FRAC_ONE)
                    t = FRAC_ONE;
                o.left      = blend(held_l, l, t);
                o.right     = blend(held_r, r, t);
                o.last      = 1'b0;
                o.block_end = (outs_in_blk == BLOCK_SAMPLES - 1);
                new_samples.push_back(o);
                n++;
                outs_in_blk++;
                nxt = interp_pos + inc;
                if (nxt > POS_CAP)
                    nxt = (POS_W + 1)'(POS_CAP);
                interp_pos = nxt[POS_W-1:0];
            end
            if (n > 0)
                new_samples[n-1].last = 1'b1;
        end
        held_l = l;
        held_r = r;
        if (in_slot == BLOCK_SAMPLES - 1)
        begin
            in_slot     = '0;
            outs_in_blk = '0;
            interp_pos  = '0;
        end
        else
        begin
            in_slot++;
        end
    endtask

    // Called and returns at a falling edge; valid stays up for a back-to-back
    // transaction and drops only on an idle cycle.
    task automatic send_sample(
        input logic signed [SAMPLE_W-1:0] l,
        input logic signed [SAMPLE_W-1:0] r,
        input row_check_t                 chk,
        input logic signed [SAMPLE_W-1:0] el,
        input logic signed [SAMPLE_W-1:0] er
    );
        resamp_out_t typed;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_left  <= l;
        in_right <= r;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        interpolate_ahead(l, r);
        if (chk == CHK_MODEL)
        begin
            foreach (new_samples[i])
                due_samples.push_back(new_samples[i]);
        end
        else if (chk == CHK_ONE)
        begin
            typed.left      = el;
            typed.right     = er;
            typed.last      = 1'b1;
            typed.block_end = 1'b0;
            due_samples.push_back(typed);
        end
        @(negedge clk);
    endtask

    // Drop valid, drain all results, then let the pipeline settle.
    task automatic quiesce();
        in_valid <= 1'b0;
        while (due_samples.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYC) @(negedge clk);
    endtask

    task automatic write_step(input logic [STEP_W-1:0] v);
        quiesce();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        step_now = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_idling(input idle_mode_t m);
        case (m)
            IDLE_NONE: begin send_idle_pct = 0;  stall_pct = 0;  end
            IDLE_SEND: begin send_idle_pct = 53; stall_pct = 0;  end
            IDLE_RECV: begin send_idle_pct = 0;  stall_pct = 53; end
            default:   begin send_idle_pct = 14; stall_pct = 14; end
        endcase
    endtask

    always @(posedge clk)
    begin : check_outputs
        resamp_out_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (due_samples.size() == 0)
            begin
                $error("output transaction with none expected: left %0d right %0d",
                       out_left, out_right);
                mismatches++;
            end
            else
            begin
                e = due_samples.pop_front();
                if (out_left !== e.left)
                begin
                    $error("out_left: expected %0d, got %0d", e.left, out_left);
                    mismatches++;
                end
                if (out_right !== e.right)
                begin
                    $error("out_right: expected %0d, got %0d", e.right, out_right);
                    mismatches++;
                end
                if (last !== e.last)
                begin
                    $error("last: expected %0b, got %0b", e.last, last);
                    mismatches++;
                end
                if (block_end !== e.block_end)
                begin
                    $error("block_end: expected %0b, got %0b", e.block_end, block_end);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin : stimulus
        int rand_items;
        int phase;
        int n;
        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        in_left   = '0;
        in_right  = '0;
        out_ready = 1'b0;
        rand_items = 0;
        phase      = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed rows, step starts at its reset value of 1.0
        foreach (dir_rows[i])
        begin
            set_idling(idle_mode_t'(i % 4));
            if (dir_rows[i].wr_step)
                write_step(dir_rows[i].step);
            send_sample(dir_rows[i].left, dir_rows[i].right, dir_rows[i].check,
                        dir_rows[i].exp_left, dir_rows[i].exp_right);
        end

        // random phases; steps change mid-block between phases
        while (rand_items < RANDOM_ITEMS)
        begin
            set_idling(idle_mode_t'(phase % 4));
            write_step(any_step());
            n = $urandom_range(8, 40);
            repeat (n)
            begin
                send_sample(any_sample(), any_sample(), CHK_MODEL, '0, '0);
                rand_items++;
            end
            phase++;
        end

        in_valid <= 1'b0;
        while (due_samples.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/slr_pkg.sv
rtl/core/slr_lerp_unit.sv
rtl/core/slr_ctrl.sv
rtl/core/stereo_linear_resampler_core.sv
sim/tb.sv
